// File: sv/bmf_pkg.sv
`default_nettype none
package bmf_pkg;

   localparam int LIST_MAX      = 128;
   localparam int ALPHABET_SIZE = 256;

   localparam int SYM_W      = 8;
   localparam int MODE_CNT_W = 8;
   localparam int ADDR_W     = $clog2(ALPHABET_SIZE);
   localparam int CNT_W      = $clog2(LIST_MAX + 1);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LIST_MAX);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

endpackage
`default_nettype wire

// File: sv/bmf_ram.sv
`default_nettype none
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: sv/byte_mode_finder.sv
`default_nettype none
// Streaming mode finder over a list of byte symbols. One request is taken
// per cycle; the per-symbol count store is a registered RAM read at accept
// time and written back as the request leaves the s1 stage, with the last
// written entry forwarded so repeated symbols run back to back. The last
// request of a list passes through the s1 register into the response
// register. Counts saturate at LIST_MAX. A per-entry valid bit clears the
// whole count store in the cycle after a list ends, so the next list may
// start immediately. The request side stalls only while a finished response
// waits and the next last request needs the output register.
module byte_mode_finder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] symbol
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [7:0] mode_symbol, [15:8] mode_count
   output logic             rsp_tuser    // mode_unique
);

   logic                                   req_acc;
   logic                                   s1_adv;
   logic                                   out_free;

   logic                                   s1_vld_ff, s1_vld_in;
   bmf_pkg::addr_type                      s1_sym_ff, s1_sym_in;
   logic                                   s1_last_ff, s1_last_in;

   logic                                   fwd_vld_ff, fwd_vld_in;
   bmf_pkg::addr_type                      fwd_sym_ff, fwd_sym_in;
   bmf_pkg::cnt_type                       fwd_cnt_ff, fwd_cnt_in;

   logic [bmf_pkg::ALPHABET_SIZE-1:0]      cnt_vld_ff, cnt_vld_in;

   bmf_pkg::cnt_type                       best_cnt_ff, best_cnt_in;
   bmf_pkg::addr_type                      best_sym_ff, best_sym_in;
   logic                                   tie_free_ff, tie_free_in;

   logic                                   rsp_vld_ff, rsp_vld_in;
   logic [bmf_pkg::SYM_W-1:0]              rsp_sym_ff, rsp_sym_in;
   logic [bmf_pkg::MODE_CNT_W-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic                                   rsp_uniq_ff, rsp_uniq_in;

   bmf_pkg::cnt_type                       ram_rdata;
   bmf_pkg::cnt_type                       base_cnt;
   bmf_pkg::cnt_type                       new_cnt;
   bmf_pkg::cnt_type                       upd_cnt;
   bmf_pkg::addr_type                      upd_sym;
   logic                                   upd_tie_free;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign s1_adv     = s1_vld_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_vld_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   bmf_ram #(
      .WIDTH (bmf_pkg::CNT_W),
      .DEPTH (bmf_pkg::ALPHABET_SIZE)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_sym_ff),
      .wr_data (new_cnt),
      .rd_en   (req_acc),
      .rd_addr (req_tdata[bmf_pkg::ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // count lookup with forwarding of the most recent write-back
   always_comb begin
      priority if (fwd_vld_ff && (fwd_sym_ff == s1_sym_ff)) begin
         base_cnt = fwd_cnt_ff;
      end else if (cnt_vld_ff[s1_sym_ff]) begin
         base_cnt = ram_rdata;
      end else begin
         base_cnt = '0;
      end
      new_cnt = (base_cnt < bmf_pkg::CNT_MAX) ? base_cnt + 1'b1 : base_cnt;
   end

   // running best and tie tracking
   always_comb begin
      upd_cnt      = best_cnt_ff;
      upd_sym      = best_sym_ff;
      upd_tie_free = tie_free_ff;
      priority if (new_cnt > best_cnt_ff) begin
         upd_cnt      = new_cnt;
         upd_sym      = s1_sym_ff;
         upd_tie_free = 1'b1;
      end else if ((new_cnt == best_cnt_ff) && (s1_sym_ff != best_sym_ff)) begin
         upd_tie_free = 1'b0;
      end else begin
         upd_tie_free = tie_free_ff;
      end
   end

   always_comb begin
      s1_vld_in   = s1_vld_ff;
      s1_sym_in   = s1_sym_ff;
      s1_last_in  = s1_last_ff;
      fwd_vld_in  = fwd_vld_ff;
      fwd_sym_in  = fwd_sym_ff;
      fwd_cnt_in  = fwd_cnt_ff;
      cnt_vld_in  = cnt_vld_ff;
      best_cnt_in = best_cnt_ff;
      best_sym_in = best_sym_ff;
      tie_free_in = tie_free_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_sym_in  = rsp_sym_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_uniq_in = rsp_uniq_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      if (s1_adv) begin
         s1_vld_in = 1'b0;
         if (s1_last_ff) begin
            fwd_vld_in  = 1'b0;
            cnt_vld_in  = '0;
            best_cnt_in = '0;
            best_sym_in = '0;
            tie_free_in = 1'b1;
            rsp_vld_in  = 1'b1;
            rsp_sym_in  = bmf_pkg::SYM_W'(upd_sym);
            rsp_cnt_in  = bmf_pkg::MODE_CNT_W'(upd_cnt);
            rsp_uniq_in = upd_tie_free;
         end else begin
            fwd_vld_in             = 1'b1;
            fwd_sym_in             = s1_sym_ff;
            fwd_cnt_in             = new_cnt;
            cnt_vld_in[s1_sym_ff]  = 1'b1;
            best_cnt_in            = upd_cnt;
            best_sym_in            = upd_sym;
            tie_free_in            = upd_tie_free;
         end
      end

      if (req_acc) begin
         s1_vld_in  = 1'b1;
         s1_sym_in  = req_tdata[bmf_pkg::ADDR_W-1:0];
         s1_last_in = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s1_last_ff  <= 1'b0;
         fwd_vld_ff  <= 1'b0;
         cnt_vld_ff  <= '0;
         best_cnt_ff <= '0;
         best_sym_ff <= '0;
         tie_free_ff <= 1'b1;
         rsp_vld_ff  <= 1'b0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         s1_last_ff  <= s1_last_in;
         fwd_vld_ff  <= fwd_vld_in;
         cnt_vld_ff  <= cnt_vld_in;
         best_cnt_ff <= best_cnt_in;
         best_sym_ff <= best_sym_in;
         tie_free_ff <= tie_free_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      s1_sym_ff   <= s1_sym_in;
      fwd_sym_ff  <= fwd_sym_in;
      fwd_cnt_ff  <= fwd_cnt_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_uniq_ff <= rsp_uniq_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_sym_ff};
   assign rsp_tuser  = rsp_uniq_ff;

`ifndef SYNTH
   a_rsp_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_cnt_ff != '0))
      else $error("response with zero mode count");

   a_rsp_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_cnt_ff <= bmf_pkg::MODE_CNT_W'(bmf_pkg::LIST_MAX)))
      else $error("mode count above list bound");

   a_list_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (!fwd_vld_ff && (cnt_vld_ff == '0) && tie_free_ff
                                  && (best_cnt_ff == '0)))
      else $error("count store not cleared after list end");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_vld_ff && s1_last_ff && rsp_vld_ff && !rsp_tready))
      else $error("request stall without a blocked response");
`endif

endmodule
`default_nettype wire
